// ===== rtl/bfas_pkg.sv =====
// shared types and constants for the bf16 add/subtract pipeline
`default_nettype none

package bfas_pkg;

    // bf16 field layout
    localparam int BF_W     = 16;
    localparam int EXP_W    = 8;
    localparam int FRAC_W   = 7;
    localparam int MANT_W   = FRAC_W + 1;

    // fp32 layout used for the intermediate result
    localparam int FP_W      = 32;
    localparam int FP_FRAC_W = 23;

    // alignment frame: big significand sits at the top, carry bit above it
    localparam int FRAME_W  = 40;
    localparam int SUM_W    = FRAME_W + 1;
    localparam int EXT_W    = 2 * FRAME_W;
    localparam int SHIFT_W  = 6;
    localparam int SHIFT_MAX = 47;
    localparam int LZ_W     = 6;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [FP_W-1:0]  BF_ROUND_BIAS = 32'h0000_7FFF;
    localparam logic [BF_W-1:0]  NAN_PATTERN_RESET = 16'h7FC0;
    localparam logic [BF_W-2:0]  BF_INF_MAG = 15'h7F80;

    // operation codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // special-case flags carried alongside the data
    typedef struct packed {
        logic nan;
        logic inf;
        logic inf_sign;
    } bfas_flags_t;

    // after unpack and operand ordering
    typedef struct packed {
        bfas_flags_t        flags;
        logic               sign;
        logic               eff_sub;
        logic               zero_sign;
        logic [EXP_W-1:0]   big_exp;
        logic [MANT_W-1:0]  big_mant;
        logic [MANT_W-1:0]  small_mant;
        logic [EXP_W-1:0]   diff;
    } bfas_s1_t;

    // after alignment and add
    typedef struct packed {
        bfas_flags_t        flags;
        logic               sign;
        logic               zero_sign;
        logic [EXP_W-1:0]   big_exp;
        logic [SUM_W-1:0]   sum;
    } bfas_s2_t;

    // after normalisation
    typedef struct packed {
        bfas_flags_t        flags;
        logic               sign;
        logic [EXP_W:0]     exp;
        logic [SUM_W-1:0]   norm;
    } bfas_s3_t;

endpackage

`default_nettype wire

// ===== rtl/bfas_align.sv =====
// unpack, operand ordering, alignment shift and significand add
`default_nettype none

module bfas_align (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_take,
    input  wire logic                        cmd,
    input  wire logic [bfas_pkg::BF_W-1:0]   lhs_value,
    input  wire logic [bfas_pkg::BF_W-1:0]   rhs_value,
    output logic                             s2_valid,
    output bfas_pkg::bfas_s2_t               s2
);

    logic               s1_valid_reg;
    bfas_pkg::bfas_s1_t s1_reg;
    bfas_pkg::bfas_s1_t s1_next;
    logic               s2_valid_reg;
    bfas_pkg::bfas_s2_t s2_reg;
    bfas_pkg::bfas_s2_t s2_next;

    // unpack and order the operands by magnitude
    always_comb
    begin
        logic                         sa;
        logic                         sb;
        logic [bfas_pkg::EXP_W-1:0]   ea;
        logic [bfas_pkg::EXP_W-1:0]   eb;
        logic [bfas_pkg::FRAC_W-1:0]  fa;
        logic [bfas_pkg::FRAC_W-1:0]  fb;
        logic                         nan_a;
        logic                         nan_b;
        logic                         inf_a;
        logic                         inf_b;
        logic                         swap;
        logic [bfas_pkg::EXP_W-1:0]   xa;
        logic [bfas_pkg::EXP_W-1:0]   xb;
        logic [bfas_pkg::MANT_W-1:0]  ma;
        logic [bfas_pkg::MANT_W-1:0]  mb;

        sa = lhs_value[15];
        sb = rhs_value[15] ^ (cmd == bfas_pkg::CMD_SUB);
        ea = lhs_value[14:7];
        eb = rhs_value[14:7];
        fa = lhs_value[6:0];
        fb = rhs_value[6:0];
        nan_a = (ea == bfas_pkg::EXP_ALL_ONES) && (fa != '0);
        nan_b = (eb == bfas_pkg::EXP_ALL_ONES) && (fb != '0);
        inf_a = (ea == bfas_pkg::EXP_ALL_ONES) && (fa == '0);
        inf_b = (eb == bfas_pkg::EXP_ALL_ONES) && (fb == '0);
        xa = (ea == '0) ? 8'd1 : ea;
        xb = (eb == '0) ? 8'd1 : eb;
        ma = {(ea != '0), fa};
        mb = {(eb != '0), fb};
        swap = rhs_value[14:0] > lhs_value[14:0];

        // invalid infinity pair: effective signs differ
        s1_next.flags.nan      = nan_a || nan_b || (inf_a && inf_b && (sa != sb));
        s1_next.flags.inf      = inf_a || inf_b;
        s1_next.flags.inf_sign = inf_a ? sa : sb;
        s1_next.sign       = swap ? sb : sa;
        s1_next.eff_sub    = sa ^ sb;
        s1_next.zero_sign  = sa & sb;
        s1_next.big_exp    = swap ? xb : xa;
        s1_next.big_mant   = swap ? mb : ma;
        s1_next.small_mant = swap ? ma : mb;
        s1_next.diff       = swap ? (xb - xa) : (xa - xb);
    end

    // align the smaller significand and add or subtract
    always_comb
    begin
        logic [bfas_pkg::SHIFT_W-1:0] shc;
        logic [bfas_pkg::EXT_W-1:0]   ext;
        logic [bfas_pkg::FRAME_W-1:0] small_al;
        logic [bfas_pkg::FRAME_W-1:0] big_al;
        logic                         sticky;

        shc = (s1_reg.diff > 8'(bfas_pkg::SHIFT_MAX)) ? 6'(bfas_pkg::SHIFT_MAX)
                                                      : s1_reg.diff[5:0];
        ext = {s1_reg.small_mant, {(bfas_pkg::EXT_W-bfas_pkg::MANT_W){1'b0}}} >> shc;
        sticky = |ext[bfas_pkg::FRAME_W-1:0];
        small_al = ext[bfas_pkg::EXT_W-1:bfas_pkg::FRAME_W];
        small_al[0] = small_al[0] | sticky;
        big_al = {s1_reg.big_mant, {(bfas_pkg::FRAME_W-bfas_pkg::MANT_W){1'b0}}};

        s2_next.flags     = s1_reg.flags;
        s2_next.sign      = s1_reg.sign;
        s2_next.zero_sign = s1_reg.zero_sign;
        s2_next.big_exp   = s1_reg.big_exp;
        s2_next.sum       = s1_reg.eff_sub ? ({1'b0, big_al} - {1'b0, small_al})
                                           : ({1'b0, big_al} + {1'b0, small_al});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/bfas_norm.sv =====
// leading-zero count and normalising shift of the raw sum
`default_nettype none

module bfas_norm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                s2_valid,
    input  wire bfas_pkg::bfas_s2_t  s2,
    output logic                     s3_valid,
    output bfas_pkg::bfas_s3_t       s3
);

    logic               s3_valid_reg;
    bfas_pkg::bfas_s3_t s3_reg;
    bfas_pkg::bfas_s3_t s3_next;

    // count leading zeros, cap the shift so subnormals keep the minimum exponent
    always_comb
    begin
        logic [bfas_pkg::LZ_W-1:0]  lz;
        logic [bfas_pkg::LZ_W-1:0]  sh;
        logic [bfas_pkg::SUM_W-1:0] norm;

        lz = 6'(bfas_pkg::SUM_W);
        for (int i = 0; i < bfas_pkg::SUM_W; i++)
        begin
            if (s2.sum[i])
            begin
                lz = 6'(bfas_pkg::SUM_W - 1 - i);
            end
        end
        sh = ({2'b00, lz} > s2.big_exp) ? s2.big_exp[5:0] : lz;
        norm = s2.sum << sh;

        s3_next.flags = s2.flags;
        s3_next.sign  = (s2.sum == '0) ? s2.zero_sign : s2.sign;
        s3_next.norm  = norm;
        s3_next.exp   = norm[bfas_pkg::SUM_W-1]
                        ? ({1'b0, s2.big_exp} + 9'd1 - {3'b000, sh}) : 9'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3       = s3_reg;

endmodule

`default_nettype wire

// ===== rtl/bfas_round.sv =====
// fp32 round-to-nearest-even, then bf16 rounding and result select
`default_nettype none

module bfas_round (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       s3_valid,
    input  wire bfas_pkg::bfas_s3_t         s3,
    input  wire logic [bfas_pkg::BF_W-1:0]  nan_pattern,
    output logic                            out_valid,
    output logic [bfas_pkg::BF_W-1:0]       result_value,
    output logic                            used_nan_path
);

    logic                          s4_valid_reg;
    bfas_pkg::bfas_flags_t         s4_flags_reg;
    logic [bfas_pkg::FP_W-1:0]     s4_fp_reg;
    logic [bfas_pkg::FP_W-1:0]     s4_fp_next;
    logic                          s5_valid_reg;
    logic [bfas_pkg::BF_W-1:0]     s5_result_reg;
    logic [bfas_pkg::BF_W-1:0]     s5_result_next;
    logic                          s5_nan_reg;

    // fp32 rounding; exponent overflow goes to infinity
    always_comb
    begin
        logic                       inc;
        logic [bfas_pkg::FP_W-2:0]  mag;

        inc = s3.norm[16] & ((|s3.norm[15:0]) | s3.norm[17]);
        mag = {s3.exp[7:0], s3.norm[39:17]} + 31'(inc);
        if (s3.exp >= {1'b0, bfas_pkg::EXP_ALL_ONES})
        begin
            s4_fp_next = {s3.sign, bfas_pkg::EXP_ALL_ONES, {bfas_pkg::FP_FRAC_W{1'b0}}};
        end
        else
        begin
            s4_fp_next = {s3.sign, mag};
        end
    end

    // bf16 rounding and special-case select
    always_comb
    begin
        logic [bfas_pkg::FP_W-1:0] w;

        w = s4_fp_reg + bfas_pkg::BF_ROUND_BIAS + {31'b0, s4_fp_reg[16]};
        if (s4_flags_reg.nan)
        begin
            s5_result_next = nan_pattern;
        end
        else if (s4_flags_reg.inf)
        begin
            s5_result_next = {s4_flags_reg.inf_sign, bfas_pkg::BF_INF_MAG};
        end
        else
        begin
            s5_result_next = w[31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_flags_reg  <= s3.flags;
            s4_fp_reg     <= s4_fp_next;
            s5_result_reg <= s5_result_next;
            s5_nan_reg    <= s4_flags_reg.nan;
        end
    end

    assign out_valid     = s5_valid_reg;
    assign result_value  = s5_result_reg;
    assign used_nan_path = s5_nan_reg;

endmodule

`default_nettype wire

// ===== rtl/bf16_add_sub_unit.sv =====
// top level of the bf16 adder/subtractor
//
// Adds or subtracts two bf16 operands (cmd 0 add, 1 subtract). The operands
// are widened to fp32, summed with round-to-nearest-even (subnormals kept) and
// rounded back to bf16. NaN operands and invalid infinity pairs return the
// programmed NaN pattern with used_nan_path set.
// Input channel: in_valid/in_ready with cmd, lhs_value, rhs_value.
// Output channel: out_valid/out_ready with result_value, used_nan_path.
// Config channel: cfg_valid/cfg_ready with cfg_data, the NaN pattern; always
// ready, to be written only while no transaction is in flight.
// The five pipeline registers (order, align/add, normalise, fp32 round, bf16 round)
// lie between an input transaction and its result valid.
// Throughput: one transaction per cycle while the receiver does not stall the output.
// Reset clears every valid bit and loads the NaN pattern with 0x7FC0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module bf16_add_sub_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic [bfas_pkg::BF_W-1:0]  lhs_value,
    input  wire logic [bfas_pkg::BF_W-1:0]  rhs_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [bfas_pkg::BF_W-1:0]       result_value,
    output logic                            used_nan_path,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bfas_pkg::BF_W-1:0]  cfg_data
);

    logic                          en;
    logic                          s2_valid;
    bfas_pkg::bfas_s2_t            s2;
    logic                          s3_valid;
    bfas_pkg::bfas_s3_t            s3;
    logic [bfas_pkg::BF_W-1:0]     nan_pattern_reg;

    // pipeline advances unless a result is held by the receiver
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // nan pattern register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nan_pattern_reg <= bfas_pkg::NAN_PATTERN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            nan_pattern_reg <= cfg_data;
        end
    end

    bfas_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_take   (in_valid && in_ready),
        .cmd       (cmd),
        .lhs_value (lhs_value),
        .rhs_value (rhs_value),
        .s2_valid  (s2_valid),
        .s2        (s2)
    );

    bfas_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s2_valid (s2_valid),
        .s2       (s2),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    bfas_round u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .s3_valid      (s3_valid),
        .s3            (s3),
        .nan_pattern   (nan_pattern_reg),
        .out_valid     (out_valid),
        .result_value  (result_value),
        .used_nan_path (used_nan_path)
    );

    // stalled output holds its transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result changed under stall");

    // nan path always carries the programmed pattern
    a_nan_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_nan_path |-> result_value == nan_pattern_reg)
        else $error("nan path result differs from pattern");

    // arithmetic path never produces a nan encoding
    a_no_arith_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !used_nan_path |->
            (result_value[14:7] != bfas_pkg::EXP_ALL_ONES) || (result_value[6:0] == '0))
        else $error("arithmetic path produced nan");

    // accepted input occupies the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> u_align.s1_valid_reg)
        else $error("accepted transaction dropped");

endmodule

`default_nettype wire

// ===== bench/bf16_add_sub_unit_test.sv =====
// self-checking testbench for the bf16 adder/subtractor with its own exact fp32 predictor
`default_nettype none

module bf16_add_sub_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIX_W      = 272;
    localparam int LATENCY    = 5;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic                       op;
        logic [bfas_pkg::BF_W-1:0]  lhs;
        logic [bfas_pkg::BF_W-1:0]  rhs;
    } operand_pair_t;

    typedef struct {
        logic [bfas_pkg::BF_W-1:0]  value;
        logic                       nan_path;
    } bf16_sum_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd = bfas_pkg::CMD_ADD;
    logic [bfas_pkg::BF_W-1:0]  lhs_value = '0;
    logic [bfas_pkg::BF_W-1:0]  rhs_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [bfas_pkg::BF_W-1:0]  result_value;
    logic                       used_nan_path;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [bfas_pkg::BF_W-1:0]  cfg_data = '0;

    operand_pair_t              pending_pairs[$];
    bf16_sum_t                  expected_sums[$];
    logic [bfas_pkg::BF_W-1:0]  nan_pattern_copy = bfas_pkg::NAN_PATTERN_RESET;
    bit                         idle_on = 1'b1;
    int                         fail_count = 0;
    int                         cycle_count = 0;

    bf16_add_sub_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .lhs_value     (lhs_value),
        .rhs_value     (rhs_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .used_nan_path (used_nan_path),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // exact bf16 widening, fp32 rne sum, then bf16 bias rounding
    function automatic bf16_sum_t predict_sum(logic op, logic [bfas_pkg::BF_W-1:0] a,
                                              logic [bfas_pkg::BF_W-1:0] b,
                                              logic [bfas_pkg::BF_W-1:0] pattern);
        bf16_sum_t              res;
        logic                   a_nan, b_nan, a_inf, b_inf, b_sign, r_sign, rnd;
        logic signed [FIX_W-1:0] fa, fb, total;
        logic [FIX_W-1:0]       mag, kept, rem, half;
        logic [31:0]            word;
        int                     p, sh, expf;
        a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 0);
        b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 0);
        a_inf  = (a[14:0] == bfas_pkg::BF_INF_MAG);
        b_inf  = (b[14:0] == bfas_pkg::BF_INF_MAG);
        b_sign = b[15] ^ (op == bfas_pkg::CMD_SUB);
        res.nan_path = a_nan || b_nan || (a_inf && b_inf && (a[15] != b_sign));
        if (res.nan_path)
        begin
            res.value = pattern;
            return res;
        end
        if (a_inf || b_inf)
        begin
            r_sign = a_inf ? a[15] : b_sign;
            word = {r_sign, 8'hFF, 23'd0};
        end
        else
        begin
            // fixed point with lsb weight 2^-133
            fa = (a[14:7] == 0) ? FIX_W'(a[6:0]) : (FIX_W'({1'b1, a[6:0]}) << (a[14:7] - 1));
            fb = (b[14:7] == 0) ? FIX_W'(b[6:0]) : (FIX_W'({1'b1, b[6:0]}) << (b[14:7] - 1));
            if (a[15]) fa = -fa;
            if (b_sign) fb = -fb;
            total = fa + fb;
            r_sign = total < 0;
            mag = r_sign ? -total : total;
            if (mag == 0)
                word = {a[15] & b_sign, 31'd0};
            else
            begin
                p = 0;
                for (int i = FIX_W - 1; i >= 0; i--)
                    if (mag[i] && p == 0) p = i;
                if (p > 23)
                begin
                    sh   = p - 23;
                    kept = mag >> sh;
                    rem  = mag & ((FIX_W'(1) << sh) - 1);
                    half = FIX_W'(1) << (sh - 1);
                    rnd  = (rem > half) || ((rem == half) && kept[0]);
                    kept = kept + rnd;
                    if (kept[24])
                    begin
                        kept = kept >> 1;
                        p++;
                    end
                end
                else
                    kept = mag << (23 - p);
                expf = p - 6;
                if (expf >= 255)
                    word = {r_sign, 8'hFF, 23'd0};
                else if (expf >= 1)
                    word = {r_sign, 8'(expf), kept[22:0]};
                else
                    word = {r_sign, 8'd0, 23'(mag << 16)};
            end
        end
        word = word + bfas_pkg::BF_ROUND_BIAS + word[16];
        res.value = word[31:16];
        return res;
    endfunction

    // operand generator leaning on special encodings
    function automatic logic [bfas_pkg::BF_W-1:0] pick_bf16();
        logic [bfas_pkg::BF_W-1:0] v;
        v = bfas_pkg::BF_W'($urandom);
        case ($urandom_range(19))
            0: v[14:0] = 15'h0000;
            1: v[14:0] = bfas_pkg::BF_INF_MAG;
            2: v[14:7] = 8'hFF;
            3: v[14:7] = 8'h00;
            4: v[14:0] = 15'h7F7F;
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_pair(logic op, logic [bfas_pkg::BF_W-1:0] a,
                              logic [bfas_pkg::BF_W-1:0] b);
        operand_pair_t t;
        t.op  = op;
        t.lhs = a;
        t.rhs = b;
        pending_pairs.push_back(t);
    endtask

    task automatic queue_random(int count);
        logic [bfas_pkg::BF_W-1:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            a = pick_bf16();
            b = pick_bf16();
            // near cancellation and near alignment
            if ($urandom_range(3) == 0)
                b = a ^ bfas_pkg::BF_W'($urandom_range(3))
                      ^ {1'($urandom_range(1)), 15'd0};
            queue_pair(1'($urandom), a, b);
        end
    endtask

    task automatic write_nan_pattern(logic [bfas_pkg::BF_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        nan_pattern_copy = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && !in_valid && expected_sums.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_sums.push_back(predict_sum(cmd, lhs_value, rhs_value,
                                                    nan_pattern_copy));
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() > 0 && !(idle_on && $urandom_range(99) < 18))
                begin
                    operand_pair_t t;
                    t = pending_pairs.pop_front();
                    cmd       <= t.op;
                    lhs_value <= t.lhs;
                    rhs_value <= t.rhs;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("result transaction with nothing expected: result_value %h",
                           result_value);
                    fail_count++;
                end
                else
                begin
                    bf16_sum_t e;
                    e = expected_sums.pop_front();
                    if (result_value !== e.value)
                    begin
                        $error("result_value expected %h actual %h", e.value, result_value);
                        fail_count++;
                    end
                    if (used_nan_path !== e.nan_path)
                    begin
                        $error("used_nan_path expected %b actual %b", e.nan_path,
                               used_nan_path);
                        fail_count++;
                    end
                end
            end
            out_ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // special cases under the reset nan pattern
        queue_pair(bfas_pkg::CMD_ADD, 16'h7FC1, 16'h3F80);
        queue_pair(bfas_pkg::CMD_SUB, 16'h3F80, 16'hFF81);
        queue_pair(bfas_pkg::CMD_ADD, 16'h7F80, 16'hFF80);
        queue_pair(bfas_pkg::CMD_SUB, 16'hFF80, 16'hFF80);
        queue_pair(bfas_pkg::CMD_ADD, 16'h7F80, 16'h7F80);
        queue_pair(bfas_pkg::CMD_SUB, 16'h7F80, 16'hFF80);
        queue_pair(bfas_pkg::CMD_ADD, 16'hFF80, 16'h4000);
        queue_pair(bfas_pkg::CMD_ADD, 16'h0000, 16'h8000);
        queue_pair(bfas_pkg::CMD_ADD, 16'h8000, 16'h8000);
        queue_pair(bfas_pkg::CMD_SUB, 16'h8000, 16'h0000);
        queue_pair(bfas_pkg::CMD_SUB, 16'h0000, 16'h0000);
        queue_pair(bfas_pkg::CMD_ADD, 16'h4049, 16'hC049);
        queue_pair(bfas_pkg::CMD_ADD, 16'h7F7F, 16'h7F7F);
        queue_pair(bfas_pkg::CMD_SUB, 16'hFF7F, 16'h7F7F);
        queue_pair(bfas_pkg::CMD_ADD, 16'h7F7F, 16'h7B00);
        queue_pair(bfas_pkg::CMD_ADD, 16'h0001, 16'h0001);
        queue_pair(bfas_pkg::CMD_SUB, 16'h0001, 16'h007F);
        queue_pair(bfas_pkg::CMD_ADD, 16'h007F, 16'h0001);
        queue_pair(bfas_pkg::CMD_SUB, 16'h0080, 16'h0001);
        queue_pair(bfas_pkg::CMD_ADD, 16'h3F80, 16'h3B81);
        queue_pair(bfas_pkg::CMD_ADD, 16'h3F80, 16'h0001);
        queue_pair(bfas_pkg::CMD_SUB, 16'h3F81, 16'h3F80);
        queue_pair(bfas_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF);
        drain();

        // all-zero pattern, no idling on either side
        write_nan_pattern(16'h0000);
        idle_on = 1'b0;
        queue_random(400);
        drain();

        // all-ones pattern with idling back on
        write_nan_pattern(16'hFFFF);
        idle_on = 1'b1;
        queue_random(400);
        drain();

        write_nan_pattern(bfas_pkg::BF_W'($urandom));
        queue_random(400);
        drain();

        if (expected_sums.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bfas_pkg.sv
rtl/bfas_align.sv
rtl/bfas_norm.sv
rtl/bfas_round.sv
rtl/bf16_add_sub_unit.sv
bench/bf16_add_sub_unit_test.sv
